// ===== design/prescaler_period_search_defines.svh =====
// Assertion helpers shared by the prescaler search design.
`ifndef PRESCALER_PERIOD_SEARCH_DEFINES_SVH
`define PRESCALER_PERIOD_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PPS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prescaler search: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prescaler search: next-cycle check failed");

`endif

// ===== design/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

    // Field and datapath widths.
    localparam int FREQ_W    = 32;
    localparam int CLK_W     = 32;
    localparam int LIMIT_W   = 32;
    localparam int PRESC_W   = 16;
    localparam int PERIOD_W  = 32;
    localparam int TICKS_W   = 60;   // clock_hz * 2^28 / freq, Q.16
    localparam int DIV_REM_W = 32;
    localparam int DIV_CNT_W = 6;
    localparam int DIVD_W    = 17;   // prescaler + 1
    localparam int QUOT_W    = 33;   // rounded reload + 1
    localparam int MUL_A_W   = 33;
    localparam int PROD_W    = MUL_A_W + DIVD_W;
    localparam int ERR_W     = 32;

    localparam logic [PRESC_W-1:0] PRESCALER_MAX = 16'd65535;

    // Reset values of the configuration registers.
    localparam logic [CLK_W-1:0]   CLOCK_HZ_RST     = 32'd150000000;
    localparam logic [LIMIT_W-1:0] PERIOD_LIMIT_RST = 32'd65535;

    // Default result when nothing fits.
    localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 32'd1;

    // Last step index of the shared divider for each use.
    localparam logic [DIV_CNT_W-1:0] DIV_TICKS_LAST  = 6'd59;
    localparam logic [DIV_CNT_W-1:0] DIV_RELOAD_LAST = 6'd32;

    // Configuration register indexes.
    typedef enum logic {
        CFG_CLOCK_HZ     = 1'b0,
        CFG_PERIOD_LIMIT = 1'b1
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_CHECK,
        ST_MUL_M,
        ST_SKIP,
        ST_DIV_R,
        ST_MUL_E,
        ST_ERR,
        ST_CMP,
        ST_DONE
    } t_state;

    // Start request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] last;
    } t_div_ctl;

endpackage

`default_nettype wire

// ===== design/pps_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator is loaded
// MSB-aligned; after last+1 steps the low bits of the shift register hold
// the quotient. The starting remainder must be below the divisor.
module pps_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pps_pkg::t_div_ctl             i_ctl,
    input  wire logic [pps_pkg::TICKS_W-1:0]   i_num,
    input  wire logic [pps_pkg::DIV_REM_W-1:0] i_rem_init,
    input  wire logic [pps_pkg::DIV_REM_W-1:0] i_den,
    output logic                               o_done,
    output logic [pps_pkg::TICKS_W-1:0]        o_quot
);
    import pps_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_CNT_W-1:0] r_last, n_last;
    logic [DIV_REM_W-1:0] r_rem, n_rem;
    logic [DIV_REM_W-1:0] r_den, n_den;
    logic [TICKS_W-1:0]   r_num, n_num;
    logic [DIV_REM_W:0]   shifted;
    logic [DIV_REM_W:0]   diff;
    logic                 fits;

    // One trial subtraction per cycle.
    always_comb begin
        shifted = {r_rem, r_num[TICKS_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_last = r_last;
        n_rem  = r_rem;
        n_den  = r_den;
        n_num  = r_num;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_last = i_ctl.last;
            n_rem  = i_rem_init;
            n_den  = i_den;
            n_num  = i_num;
        end else if (r_busy) begin
            n_rem = fits ? diff[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];
            n_num = {r_num[TICKS_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == r_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_last <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// ===== design/pps_multiplier.sv =====
`default_nettype none

// Registered multiplier shared by the reload-limit and error products.
module pps_multiplier (
    input  wire logic                        i_clk,
    input  wire logic [pps_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [pps_pkg::DIVD_W-1:0]  i_b,
    output logic [pps_pkg::PROD_W-1:0]       o_prod
);
    import pps_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {{DIVD_W{1'b0}}, i_a} * {{MUL_A_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== design/prescaler_period_search.sv =====
`default_nettype none

// Timer prescaler and reload search. A transfer on the input stream carries a
// wanted update frequency in unsigned Q20.12 hertz; one transfer comes back
// with the prescaler and reload whose product of dividers lies closest to
// clock_hz / frequency, the lowest prescaler winning ties. Zero frequency or
// no fit returns prescaler 0 and reload 1. One request is handled at a time
// and the input is not ready until the result has moved into the output
// register. A single shared bit-serial divider forms the tick count, then a
// rounded reload for each prescaler whose reload fits period_limit; the scan
// ends when the reload would drop below 1, on an exact match, or after
// prescaler 65535.
// Configuration writes belong between requests.

`include "prescaler_period_search_defines.svh"

module prescaler_period_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] target_freq
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [15:0] prescaler, [47:16] period
);
    import pps_pkg::*;

    t_state                r_state, n_state;
    logic [CLK_W-1:0]      r_clock_hz;
    logic [LIMIT_W-1:0]    r_period_limit;
    logic [TICKS_W-1:0]    r_t, n_t;
    logic [PRESC_W-1:0]    r_p, n_p;
    logic                  r_have, n_have;
    logic [ERR_W-1:0]      r_best_err, n_best_err;
    logic [PRESC_W-1:0]    r_best_p, n_best_p;
    logic [PERIOD_W-1:0]   r_best_r, n_best_r;
    logic [QUOT_W-1:0]     r_q, n_q;
    logic [ERR_W-1:0]      r_err, n_err;
    logic [MUL_A_W-1:0]    r_mul_a, n_mul_a;
    logic                  r_out_valid, n_out_valid;
    logic [PRESC_W-1:0]    r_out_p, n_out_p;
    logic [PERIOD_W-1:0]   r_out_r, n_out_r;

    logic [DIVD_W-1:0]     d;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W+15:0]    actual;
    logic [PROD_W+15:0]    t_ext;
    logic [PROD_W+15:0]    abs_diff;
    logic [TICKS_W:0]      round_sum;
    logic                  in_xfer;
    logic                  stop_now;
    logic                  too_long;
    logic                  last_p;

    t_div_ctl              div_ctl;
    logic [TICKS_W-1:0]    div_num;
    logic [DIV_REM_W-1:0]  div_rem_init;
    logic [DIV_REM_W-1:0]  div_den;
    logic                  div_done;
    logic [TICKS_W-1:0]    div_quot;

    // Shared divider: tick count first, then one rounded reload per prescaler whose reload fits the limit.
    pps_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_num      (div_num),
        .i_rem_init (div_rem_init),
        .i_den      (div_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Shared multiplier: reload limit times divider, then divider times reload.
    pps_multiplier u_multiplier (
        .i_clk  (i_clk),
        .i_a    (r_mul_a),
        .i_b    (d),
        .o_prod (prod)
    );

    // Datapath terms for the current prescaler.
    always_comb begin
        d         = {1'b0, r_p} + 1'b1;
        t_ext     = {{(PROD_W+16-TICKS_W){1'b0}}, r_t};
        actual    = {prod, 16'd0};
        abs_diff  = (actual >= t_ext) ? (actual - t_ext) : (t_ext - actual);
        round_sum = {1'b0, r_t} + {{(TICKS_W+1-DIVD_W-15){1'b0}}, d, 15'd0};
        stop_now  = r_t < {{(TICKS_W-DIVD_W-17){1'b0}}, d, 17'd0};
        too_long  = t_ext > actual;
        last_p    = r_p == PRESCALER_MAX;
        in_xfer   = s_axis_tvalid && s_axis_tready;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz     <= CLOCK_HZ_RST;
            r_period_limit <= PERIOD_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CLOCK_HZ:     r_clock_hz     <= i_cfg_wdata;
                CFG_PERIOD_LIMIT: r_period_limit <= i_cfg_wdata;
                default:          r_clock_hz     <= r_clock_hz;
            endcase
        end
    end

    // Sequencer: next state, search bookkeeping and divider requests.
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_p         = r_p;
        n_have      = r_have;
        n_best_err  = r_best_err;
        n_best_p    = r_best_p;
        n_best_r    = r_best_r;
        n_q         = r_q;
        n_err       = r_err;
        n_mul_a     = r_mul_a;
        n_out_valid = r_out_valid;
        n_out_p     = r_out_p;
        n_out_r     = r_out_r;

        div_ctl.start = 1'b0;
        div_ctl.last  = DIV_RELOAD_LAST;
        div_num       = {round_sum[QUOT_W+15:16], {(TICKS_W-QUOT_W){1'b0}}};
        div_rem_init  = {{(DIV_REM_W-(TICKS_W-QUOT_W-15)){1'b0}},
                         round_sum[TICKS_W:QUOT_W+16]};
        div_den       = {{(DIV_REM_W-DIVD_W){1'b0}}, d};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_p        = '0;
                    n_have     = 1'b0;
                    n_best_err = '0;
                    n_best_p   = '0;
                    n_best_r   = PERIOD_DEFAULT;
                    if (s_axis_tdata == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        div_ctl.start = 1'b1;
                        div_ctl.last  = DIV_TICKS_LAST;
                        div_num       = {r_clock_hz, 28'd0};
                        div_rem_init  = '0;
                        div_den       = s_axis_tdata;
                        n_state       = ST_DIV_T;
                    end
                end
            end
            ST_DIV_T: begin
                if (div_done) begin
                    n_t     = div_quot;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Stop once the unrounded reload would fall below one.
                if (stop_now) begin
                    n_state = ST_DONE;
                end else begin
                    n_mul_a = {1'b0, r_period_limit} + 1'b1;
                    n_state = ST_MUL_M;
                end
            end
            ST_MUL_M: begin
                n_state = ST_SKIP;
            end
            ST_SKIP: begin
                // Skip prescalers whose reload would exceed the limit.
                if (too_long) begin
                    if (last_p) begin
                        n_state = ST_DONE;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = ST_CHECK;
                    end
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (div_done) begin
                    n_q     = div_quot[QUOT_W-1:0];
                    n_mul_a = div_quot[QUOT_W-1:0];
                    n_state = ST_MUL_E;
                end
            end
            ST_MUL_E: begin
                n_state = ST_ERR;
            end
            ST_ERR: begin
                n_err   = abs_diff[ERR_W-1:0];
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // Keep the first prescaler with the strictly smallest error.
                n_state = ST_CHECK;
                if (!r_have || (r_err < r_best_err)) begin
                    n_have     = 1'b1;
                    n_best_err = r_err;
                    n_best_p   = r_p;
                    n_best_r   = PERIOD_W'(r_q - 1'b1);
                end
                if ((!r_have || (r_err < r_best_err)) && (r_err == '0)) begin
                    n_state = ST_DONE;
                end else if (last_p) begin
                    n_state = ST_DONE;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_p     = r_best_p;
                    n_out_r     = r_best_r;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_p         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_p         <= n_p;
        end
        r_t        <= n_t;
        r_best_err <= n_best_err;
        r_best_p   <= n_best_p;
        r_best_r   <= n_best_r;
        r_q        <= n_q;
        r_err      <= n_err;
        r_mul_a    <= n_mul_a;
        r_out_p    <= n_out_p;
        r_out_r    <= n_out_r;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_p};

    // The divider only finishes while the sequencer waits for it.
    `PPS_ASSERT_NOW(a_div_done_expected, div_done, (r_state == ST_DIV_T) || (r_state == ST_DIV_R))
    // A nonzero request always starts the tick-count division.
    `PPS_ASSERT_NEXT(a_start_division, in_xfer && (s_axis_tdata != '0), r_state == ST_DIV_T)
    // The kept prescaler never runs ahead of the one being scored.
    `PPS_ASSERT_NOW(a_best_not_ahead, (r_state == ST_CMP) && r_have, r_best_p <= r_p)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import pps_pkg::*;

    // Cycles without any transfer before the run is declared hung. The slowest
    // legal request scans every prescaler.
    localparam int WATCHDOG_LIMIT   = 8_000_000;
    // Random requests aim at a tick count of at most this many timer clocks,
    // which keeps every scan down to a few hundred prescalers.
    localparam int RANDOM_MAX_TICKS = 300;

    // One result: chosen prescaler and reload, laid out as on m_axis_tdata.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PRESC_W-1:0]  prescaler;
    } t_fit;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    t_cfg_index  cfg_index     = CFG_CLOCK_HZ;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] target_freq
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [15:0] prescaler, [47:16] period

    // Local copy of the configuration registers.
    logic [CLK_W-1:0]   clock_hz_cfg     = CLOCK_HZ_RST;
    logic [LIMIT_W-1:0] period_limit_cfg = PERIOD_LIMIT_RST;

    t_fit fit_q[$];
    int   mismatch_count = 0;
    bit   idle_en        = 1'b1;
    int   quiet_cycles   = 0;
    int   stall_left     = 0;

    prescaler_period_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Best-fit search over the prescalers, in exact Q.16 tick arithmetic.
    function automatic t_fit predict_fit(input logic [FREQ_W-1:0] freq);
        bit [63:0] ticks;
        bit [63:0] best_err;
        bit [63:0] d;
        bit [63:0] m;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] r;
        bit [63:0] actual;
        bit [63:0] err;
        bit        have;
        t_fit      fit;
        fit.prescaler = '0;
        fit.period    = PERIOD_DEFAULT;
        have          = 1'b0;
        best_err      = '0;
        if (freq == '0) begin
            return fit;
        end
        ticks = (64'(clock_hz_cfg) << 28) / 64'(freq);
        hi    = ticks >> 16;
        lo    = ticks & 64'hFFFF;
        for (int p = 0; p <= int'(PRESCALER_MAX); p++) begin
            d = 64'(p) + 64'd1;
            // The reload would drop below one from here on.
            if (ticks < (d << 17)) begin
                break;
            end
            // The reload would exceed the period limit.
            m = (64'(period_limit_cfg) + 64'd1) * d;
            if (hi > m || (hi == m && lo != 0)) begin
                continue;
            end
            r      = (2 * ticks + (d << 16)) / (d << 17) - 64'd1;
            actual = (d * (r + 64'd1)) << 16;
            err    = (actual >= ticks) ? actual - ticks : ticks - actual;
            if (!have || err < best_err) begin
                have          = 1'b1;
                best_err      = err;
                fit.prescaler = p[PRESC_W-1:0];
                fit.period    = r[PERIOD_W-1:0];
                if (err == 0) begin
                    break;
                end
            end
        end
        return fit;
    endfunction

    // Random frequency whose tick count lands near a random value up to
    // max_ticks, with a random fraction; now and then a zero frequency.
    function automatic logic [31:0] pick_freq(input int unsigned max_ticks);
        bit [63:0] scaled;
        bit [63:0] divisor;
        bit [63:0] f;
        if ($urandom_range(19, 0) == 0) begin
            return '0;
        end
        scaled  = 64'(clock_hz_cfg) << 20;
        divisor = 64'($urandom_range(max_ticks, 1)) * 256 + 64'($urandom_range(255, 0));
        f       = scaled / divisor;
        if (f == 0) begin
            f = 64'd1;
        end
        if (f > 64'hFFFF_FFFF) begin
            f = 64'hFFFF_FFFF;
        end
        return f[31:0];
    endfunction

    // Drive one request and record its expected result once the transfer
    // happens. Entered and left at a falling edge; tvalid is left high so the
    // next request can follow back to back.
    task automatic send_freq(input logic [31:0] freq);
        int gap;
        if (idle_en && $urandom_range(2, 0) == 0) begin
            gap = $urandom_range(6, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= freq;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fit_q.push_back(predict_fit(freq));
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_fits_done();
        s_axis_tvalid <= 1'b0;
        while (fit_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write both registers on consecutive cycles; only while idle.
    task automatic write_config(input logic [31:0] clk_hz, input logic [31:0] limit);
        i_cfg_wr_en <= 1'b1;
        cfg_index   <= CFG_CLOCK_HZ;
        i_cfg_wdata <= clk_hz;
        @(negedge i_clk);
        cfg_index   <= CFG_PERIOD_LIMIT;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        clock_hz_cfg     = clk_hz;
        period_limit_cfg = limit;
    endtask

    // A run of random requests; pause_at, if not negative, is the request
    // before which the sender waits for all outstanding results.
    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                wait_fits_done();
            end
            send_freq(pick_freq(RANDOM_MAX_TICKS));
        end
        wait_fits_done();
    endtask

    // Reset register values: zero, exact fits, one hertz, the largest and
    // smallest frequencies (the smallest fits no prescaler at all).
    task automatic test_reset_values();
        send_freq(32'd0);
        send_freq(32'd4096000);
        send_freq(32'd204800000);
        send_freq(32'd4096);
        send_freq(32'h8000_0000);
        send_freq(32'hFFFF_FFFF);
        send_freq(32'd1);
        wait_fits_done();
    endtask

    // Register extremes, including a zero clock and a zero period limit.
    task automatic test_register_extremes();
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_freq(32'hFFFF_FFFF);
        send_freq(32'd0);
        wait_fits_done();

        // A limit of one forces the fit onto the last usable prescaler.
        write_config(32'd1, 32'd1);
        send_freq(32'd1);
        send_freq(32'd2);
        send_freq(32'hFFFF_FFFF);
        wait_fits_done();

        write_config(32'd0, PERIOD_LIMIT_RST);
        send_freq(32'd4096);
        send_freq(32'hFFFF_FFFF);
        wait_fits_done();

        write_config(32'd5000, 32'd0);
        send_freq(32'd102400);
        wait_fits_done();

        write_config(CLOCK_HZ_RST, 32'hFFFF_FFFF);
        send_freq(32'd4096000);
        send_freq(32'd4096);
        wait_fits_done();
    endtask

    // Small limits: many prescalers are skipped before the candidates start.
    task automatic test_random_small_limit();
        write_config($urandom_range(2_000_000, 1), $urandom_range(64, 1));
        run_random(30, -1);
    endtask

    // Sixteen-bit timer, with one pause for all results mid-run.
    task automatic test_random_16bit_limit();
        write_config($urandom_range(2_000_000, 1), PERIOD_LIMIT_RST);
        run_random(35, 12);
    endtask

    // Wide random limits, both sides at full rate.
    task automatic test_random_wide_limit();
        idle_en = 1'b0;
        write_config($urandom_range(2_000_000, 1), $urandom);
        run_random(30, -1);
    endtask

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(3, 0) == 0) begin
            stall_left    = $urandom_range(5, 0);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_fit exp_fit;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fit_q.size() == 0) begin
                $error("unexpected result: prescaler %0d, period %0d",
                       m_axis_tdata[15:0], m_axis_tdata[47:16]);
                mismatch_count++;
            end else begin
                exp_fit = fit_q.pop_front();
                if (m_axis_tdata[15:0] !== exp_fit.prescaler) begin
                    $error("prescaler: expected %0d, actual %0d",
                           exp_fit.prescaler, m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[47:16] !== exp_fit.period) begin
                    $error("period: expected %0d, actual %0d",
                           exp_fit.period, m_axis_tdata[47:16]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_random_small_limit();
        test_random_16bit_limit();
        test_random_wide_limit();

        // Give any stray result time to show up.
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
